// File: design/assert_macros.svh
// Assertion macros used by the watchdog top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock edge outside reset
`define MTLW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check that a condition implies a consequence in the same cycle
`define MTLW_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// check that a condition implies a consequence in the next cycle
`define MTLW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/mtlw_pkg.sv
// Types and constants of the multi-task liveness watchdog
package mtlw_pkg;

  localparam int SLOTS     = 8;
  localparam int ID_BITS   = 16;
  localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W     = $clog2(SLOTS + 1);
  localparam int TASK_ID_W = 16;
  localparam int PERIOD_W  = 16;
  localparam int STATUS_W  = 2;
  localparam int OUT_IDX_W = 3;
  localparam int OUT_MSK_W = 8;
  localparam int OUT_CNT_W = 4;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(5000);

  typedef enum logic [2:0] {
    MODE_REG      = 3'd0,
    MODE_DEL      = 3'd1,
    MODE_SUSP     = 3'd2,
    MODE_RES      = 3'd3,
    MODE_CHECKIN  = 3'd4,
    MODE_SUSP_ALL = 3'd5,
    MODE_RES_ALL  = 3'd6,
    MODE_TICK     = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    MARK_DOWN  = 2'd0,
    MARK_ALIVE = 2'd1,
    MARK_SUSP  = 2'd2
  } mark_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  // word travelling along the row of slot cells
  typedef struct packed {
    logic               vld;
    mode_t              mode;
    logic [ID_BITS-1:0] id;
    logic               hit;
    logic [IDX_W-1:0]   index;
    logic               fire;
    logic [SLOTS-1:0]   mask;
    logic [CNT_W-1:0]   count;
  } wave_t;

endpackage

// File: design/multi_task_liveness_watchdog.sv
// Top level of the multi-task liveness watchdog: command port, tick counter, slot row
//
// Usage:
//   Command channel: drive in_mode and in_task_id with start high; the word is
//   taken at the rising edge where start is high and busy is low.
//   Result channel: out_valid is high for exactly one cycle with out_status,
//   out_slot_index, out_check_fired, out_dead_mask and out_dead_count. The
//   receiver cannot stall; the result must be taken in that cycle.
//   Configuration: cfg_data with cfg_valid writes the check period; cfg_ready is
//   always high. Write it only while the block is idle.
//   Row: a command walks the row of SLOTS slot cells one cell per cycle, and
//   its result strobes as the word leaves the last cell.
//   Ordering: one command in the row at a time; busy drops in the result cycle,
//   so the next command may be taken at the edge that ends it.
//   Reset (synchronous, rst_n low): all slots free, tick count zero, check
//   period 5000, no command in flight.
`include "assert_macros.svh"

module multi_task_liveness_watchdog (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [2:0]                          in_mode,
  input  logic [mtlw_pkg::TASK_ID_W-1:0]      in_task_id,
  output logic                                out_valid,
  output logic [mtlw_pkg::STATUS_W-1:0]       out_status,
  output logic [mtlw_pkg::OUT_IDX_W-1:0]      out_slot_index,
  output logic                                out_check_fired,
  output logic [mtlw_pkg::OUT_MSK_W-1:0]      out_dead_mask,
  output logic [mtlw_pkg::OUT_CNT_W-1:0]      out_dead_count,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mtlw_pkg::PERIOD_W-1:0]       cfg_data
);

  mtlw_pkg::wave_t                  waves [mtlw_pkg::SLOTS+1];
  mtlw_pkg::wave_t                  last;
  mtlw_pkg::mode_t                  mode_in;
  mtlw_pkg::status_t                status;
  logic [mtlw_pkg::SLOTS-1:0]       wave_vld;
  logic [mtlw_pkg::PERIOD_W-1:0]    period_r, period_nxt;
  logic [mtlw_pkg::PERIOD_W-1:0]    tick_r, tick_nxt, tick_eff;
  logic [mtlw_pkg::PERIOD_W:0]      tick_inc;
  logic                             busy_r, busy_nxt;
  logic                             accept, resume_clr, fire;

  assign mode_in    = mtlw_pkg::mode_t'(in_mode);
  assign accept     = start && !busy;
  assign last       = waves[mtlw_pkg::SLOTS];
  assign cfg_ready  = 1'b1;
  assign busy       = busy_r && !last.vld;

  // a resume that found its slot restarts the period as it leaves the row
  assign resume_clr = last.vld && (last.mode == mtlw_pkg::MODE_RES) && last.hit;
  assign tick_eff   = resume_clr ? '0 : tick_r;
  assign tick_inc   = {1'b0, tick_eff} + (mtlw_pkg::PERIOD_W+1)'(1);
  assign fire       = (tick_inc >= {1'b0, period_r});

  always_comb begin
    waves[0].vld   = accept;
    waves[0].mode  = mode_in;
    waves[0].id    = mtlw_pkg::ID_BITS'(in_task_id);
    waves[0].hit   = 1'b0;
    waves[0].index = '0;
    waves[0].fire  = (mode_in == mtlw_pkg::MODE_TICK) && fire;
    waves[0].mask  = '0;
    waves[0].count = '0;
  end

  for (genvar k = 0; k < mtlw_pkg::SLOTS; k++) begin : g_cell
    mtlw_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .slot_num (mtlw_pkg::IDX_W'(k)),
      .wave_in  (waves[k]),
      .wave_out (waves[k+1])
    );
    assign wave_vld[k] = waves[k+1].vld;
  end

  always_comb begin
    tick_nxt   = tick_eff;
    period_nxt = cfg_valid ? cfg_data : period_r;
    busy_nxt   = accept ? 1'b1 : (last.vld ? 1'b0 : busy_r);
    if (accept) begin
      case (mode_in)
        mtlw_pkg::MODE_TICK:     tick_nxt = fire ? '0 : tick_inc[mtlw_pkg::PERIOD_W-1:0];
        mtlw_pkg::MODE_SUSP_ALL: tick_nxt = '0;
        mtlw_pkg::MODE_RES_ALL:  tick_nxt = '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= mtlw_pkg::PERIOD_RESET;
      tick_r   <= '0;
      busy_r   <= 1'b0;
    end else begin
      period_r <= period_nxt;
      tick_r   <= tick_nxt;
      busy_r   <= busy_nxt;
    end
  end

  always_comb begin
    status = mtlw_pkg::ST_DONE;
    if (last.mode == mtlw_pkg::MODE_REG) begin
      status = last.hit ? mtlw_pkg::ST_DONE : mtlw_pkg::ST_FULL;
    end else if (last.mode inside {mtlw_pkg::MODE_DEL, mtlw_pkg::MODE_SUSP,
                                   mtlw_pkg::MODE_RES, mtlw_pkg::MODE_CHECKIN}) begin
      status = last.hit ? mtlw_pkg::ST_DONE : mtlw_pkg::ST_NOT_FOUND;
    end
  end

  assign out_valid       = last.vld;
  assign out_status      = status;
  assign out_slot_index  = mtlw_pkg::OUT_IDX_W'(last.index);
  assign out_check_fired = last.fire;
  assign out_dead_mask   = mtlw_pkg::OUT_MSK_W'(last.mask);
  assign out_dead_count  = mtlw_pkg::OUT_CNT_W'(last.count);

  `MTLW_ASSERT(a_one_word_in_row, $onehot0(wave_vld), "more than one word in the slot row")
  `MTLW_ASSERT_IMPL(a_idle_row_empty, !busy_r, wave_vld == '0, "word in row while idle")
  `MTLW_ASSERT_IMPL(a_result_when_busy, out_valid, busy_r, "result strobe without command")
  `MTLW_ASSERT_NEXT(a_accept_sets_busy, accept, busy_r, "busy not held after acceptance")
  `MTLW_ASSERT_IMPL(a_fire_on_tick, out_valid && out_check_fired,
                    (last.mode == mtlw_pkg::MODE_TICK) && (out_status == mtlw_pkg::ST_DONE),
                    "check fired on a non-tick command")

endmodule

// File: design/mtlw_cell.sv
// One watched slot of the watchdog row, acting on the word handed along the row
module mtlw_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [mtlw_pkg::IDX_W-1:0]   slot_num,
  input  mtlw_pkg::wave_t              wave_in,
  output mtlw_pkg::wave_t              wave_out
);

  logic                           used_r, used_nxt;
  logic [mtlw_pkg::ID_BITS-1:0]   task_r, task_nxt;
  mtlw_pkg::mark_t                mark_r, mark_nxt;
  mtlw_pkg::wave_t                wave_r, wave_nxt;
  logic                           match;

  always_comb begin
    used_nxt = used_r;
    task_nxt = task_r;
    mark_nxt = mark_r;
    wave_nxt = wave_in;
    match    = used_r && (task_r == wave_in.id) && !wave_in.hit;
    if (wave_in.vld) begin
      case (wave_in.mode)
        mtlw_pkg::MODE_REG: begin
          if (!wave_in.hit && !used_r) begin
            used_nxt       = 1'b1;
            task_nxt       = wave_in.id;
            mark_nxt       = mtlw_pkg::MARK_ALIVE;
            wave_nxt.hit   = 1'b1;
            wave_nxt.index = slot_num;
          end
        end
        mtlw_pkg::MODE_DEL: begin
          if (match) begin
            used_nxt       = 1'b0;
            task_nxt       = '0;
            mark_nxt       = mtlw_pkg::MARK_DOWN;
            wave_nxt.hit   = 1'b1;
            wave_nxt.index = slot_num;
          end
        end
        mtlw_pkg::MODE_SUSP: begin
          if (match) begin
            mark_nxt       = mtlw_pkg::MARK_SUSP;
            wave_nxt.hit   = 1'b1;
            wave_nxt.index = slot_num;
          end
        end
        mtlw_pkg::MODE_RES: begin
          if (match) begin
            mark_nxt       = mtlw_pkg::MARK_DOWN;
            wave_nxt.hit   = 1'b1;
            wave_nxt.index = slot_num;
          end
        end
        mtlw_pkg::MODE_CHECKIN: begin
          if (match) begin
            mark_nxt       = mtlw_pkg::MARK_ALIVE;
            wave_nxt.hit   = 1'b1;
            wave_nxt.index = slot_num;
          end
        end
        mtlw_pkg::MODE_SUSP_ALL: begin
          if (used_r) mark_nxt = mtlw_pkg::MARK_SUSP;
        end
        mtlw_pkg::MODE_RES_ALL: begin
          if (used_r) mark_nxt = mtlw_pkg::MARK_DOWN;
        end
        mtlw_pkg::MODE_TICK: begin
          if (wave_in.fire && used_r) begin
            case (mark_r)
              mtlw_pkg::MARK_ALIVE: mark_nxt = mtlw_pkg::MARK_DOWN;
              mtlw_pkg::MARK_DOWN: begin
                wave_nxt.mask  = wave_in.mask | (mtlw_pkg::SLOTS'(1) << slot_num);
                wave_nxt.count = wave_in.count + mtlw_pkg::CNT_W'(1);
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
      task_r <= '0;
      mark_r <= mtlw_pkg::MARK_DOWN;
      wave_r <= '0;
    end else begin
      used_r <= used_nxt;
      task_r <= task_nxt;
      mark_r <= mark_nxt;
      wave_r <= wave_nxt;
    end
  end

  assign wave_out = wave_r;

endmodule
